FILE: rtl/e2r_pkg.sv
// Package for the Euler angle to rotation matrix block: payload types, constants, arctangent table.
package e2r_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int WORK_FRAC         = 30;
    localparam int WW                = 34;  // CORDIC x/y width
    localparam int ZW                = 33;  // CORDIC residual angle width
    localparam int FIELD_W           = 16;

    typedef struct packed {
        logic signed [FIELD_W-1:0] roll;
        logic signed [FIELD_W-1:0] pitch;
        logic signed [FIELD_W-1:0] yaw;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m13;
        logic signed [FIELD_W-1:0] m21;
        logic signed [FIELD_W-1:0] m22;
        logic signed [FIELD_W-1:0] m23;
        logic signed [FIELD_W-1:0] m31;
        logic signed [FIELD_W-1:0] m32;
        logic signed [FIELD_W-1:0] m33;
    } t_out;

    // One CORDIC lane as it passes from cell to cell.
    typedef struct packed {
        logic signed [WW-1:0] x;
        logic signed [WW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_lane;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0: a = 33'sd536870912;  1: a = 33'sd316933406;  2: a = 33'sd167458907;
            3: a = 33'sd85004756;   4: a = 33'sd42667331;   5: a = 33'sd21354465;
            6: a = 33'sd10680862;   7: a = 33'sd5340245;    8: a = 33'sd2670163;
            9: a = 33'sd1335087;    10: a = 33'sd667544;    11: a = 33'sd333772;
            12: a = 33'sd166886;    13: a = 33'sd83443;     14: a = 33'sd41722;
            15: a = 33'sd20861;     16: a = 33'sd10430;     17: a = 33'sd5215;
            18: a = 33'sd2608;      19: a = 33'sd1304;      20: a = 33'sd652;
            21: a = 33'sd326;       22: a = 33'sd163;       23: a = 33'sd81;
            24: a = 33'sd41;        25: a = 33'sd20;        26: a = 33'sd10;
            27: a = 33'sd5;         28: a = 33'sd3;         29: a = 33'sd1;
            30: a = 33'sd1;         default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/e2r_cell.sv
// One CORDIC micro-rotation cell applied to three lanes, with a pipeline register.
module e2r_cell #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  e2r_pkg::t_lane i_lane [3],
    output e2r_pkg::t_lane o_lane [3]
);

    e2r_pkg::t_lane n_lane [3];
    e2r_pkg::t_lane r_lane [3];

    // Rotate toward zero residual angle; shifts are arithmetic.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k].flip = i_lane[k].flip;
            if (!i_lane[k].z[e2r_pkg::ZW-1]) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STAGE);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STAGE);
                n_lane[k].z = i_lane[k].z - e2r_pkg::atan_step(STAGE);
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STAGE);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STAGE);
                n_lane[k].z = i_lane[k].z + e2r_pkg::atan_step(STAGE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

FILE: rtl/e2r_matrix.sv
// Product stages that form the nine matrix elements from the sines and cosines.
module e2r_matrix #(
    parameter int FRAC_BITS = e2r_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  e2r_pkg::t_lane      i_lane [3],
    output e2r_pkg::t_out       o_out
);

    localparam int QW = 32;  // saturated Q.30 values fit 32 bits
    localparam int SH = e2r_pkg::WORK_FRAC - FRAC_BITS;

    typedef logic signed [QW-1:0] t_q;

    function automatic t_q sat_fix(input logic signed [e2r_pkg::WW-1:0] v, input logic f);
        logic signed [e2r_pkg::WW-1:0] lim;
        logic signed [e2r_pkg::WW-1:0] c;
        lim = e2r_pkg::WW'(64'sd1 <<< e2r_pkg::WORK_FRAC);
        if (v > lim) c = lim;
        else if (v < -lim) c = -lim;
        else c = v;
        if (f) c = -c;
        return t_q'(c);
    endfunction

    function automatic t_q mulq(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = a * b + (64'sd1 <<< (e2r_pkg::WORK_FRAC - 1));
        return t_q'(p >>> e2r_pkg::WORK_FRAC);
    endfunction

    function automatic logic signed [e2r_pkg::FIELD_W-1:0] to_out(input logic signed [QW:0] v);
        logic signed [QW:0] r;
        logic signed [QW:0] lim;
        lim = (QW+1)'(64'sd1 <<< FRAC_BITS);
        if (SH > 0) r = (v + ((QW+1)'(64'sd1 <<< SH) >>> 1)) >>> SH;
        else r = v;
        if (r > lim) r = lim;
        else if (r < -lim) r = -lim;
        return r[e2r_pkg::FIELD_W-1:0];
    endfunction

    t_q r_sr, r_cr, r_sp, r_cp, r_sy, r_cy;
    t_q r2_sr, r2_cr, r2_sp, r2_cp, r2_sy, r2_cy, r_srsp, r_crsp;
    t_q r_p [13];
    e2r_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Saturate and undo the quadrant fold.
            r_cr <= sat_fix(i_lane[0].x, i_lane[0].flip);
            r_sr <= sat_fix(i_lane[0].y, i_lane[0].flip);
            r_cp <= sat_fix(i_lane[1].x, i_lane[1].flip);
            r_sp <= sat_fix(i_lane[1].y, i_lane[1].flip);
            r_cy <= sat_fix(i_lane[2].x, i_lane[2].flip);
            r_sy <= sat_fix(i_lane[2].y, i_lane[2].flip);
            // Roll times pitch products.
            r_srsp <= mulq(r_sr, r_sp);
            r_crsp <= mulq(r_cr, r_sp);
            {r2_sr, r2_cr, r2_sp, r2_cp, r2_sy, r2_cy} <= {r_sr, r_cr, r_sp, r_cp, r_sy, r_cy};
            // Second-level products, one multiplier each but for the negated pitch sine.
            r_p[0]  <= mulq(r2_cp, r2_cy);
            r_p[1]  <= mulq(r2_cp, r2_sy);
            r_p[2]  <= -r2_sp;
            r_p[3]  <= mulq(r_srsp, r2_cy);
            r_p[4]  <= mulq(r2_cr, r2_sy);
            r_p[5]  <= mulq(r_srsp, r2_sy);
            r_p[6]  <= mulq(r2_cr, r2_cy);
            r_p[7]  <= mulq(r2_sr, r2_cp);
            r_p[8]  <= mulq(r_crsp, r2_cy);
            r_p[9]  <= mulq(r2_sr, r2_sy);
            r_p[10] <= mulq(r_crsp, r2_sy);
            r_p[11] <= mulq(r2_sr, r2_cy);
            r_p[12] <= mulq(r2_cr, r2_cp);
            // Sums, rounding and saturation to the output format.
            r_out.m11 <= to_out(33'(r_p[0]));
            r_out.m12 <= to_out(33'(r_p[1]));
            r_out.m13 <= to_out(33'(r_p[2]));
            r_out.m21 <= to_out(33'(r_p[3]) - 33'(r_p[4]));
            r_out.m22 <= to_out(33'(r_p[5]) + 33'(r_p[6]));
            r_out.m23 <= to_out(33'(r_p[7]));
            r_out.m31 <= to_out(33'(r_p[8]) + 33'(r_p[9]));
            r_out.m32 <= to_out(33'(r_p[10]) - 33'(r_p[11]));
            r_out.m33 <= to_out(33'(r_p[12]));
        end
    end

    assign o_out = r_out;

endmodule

FILE: rtl/euler_to_rotation_matrix.sv
// Top level: ZYX Euler angles to direction cosine matrix through a CORDIC cell chain.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+---------------------------
//  angles   | i_valid   | o_stall   | i_data  (roll/pitch/yaw)
//  matrix   | o_valid   | i_stall   | o_data  (m11 .. m33)
//
// One triple is taken every cycle unless the output holds a stalled result; a triple passes
// the fold register, the chain of CORDIC cells and the saturation, two product and output stages.
// Reset clears only the valid pipeline. A stalled valid result on the output freezes the whole
// pipeline; the input is stalled only when the output holds a result that is stalled.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS     = e2r_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  e2r_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output e2r_pkg::t_out o_data
);

    localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = NST + 5;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Phase placement and quadrant fold, registered as the chain head.
    e2r_pkg::t_lane n_head [3];
    e2r_pkg::t_lane r_head [3];
    logic [ANGLE_BITS-1:0] w_ang [3];
    assign w_ang[0] = ANGLE_BITS'(unsigned'(i_data.roll));
    assign w_ang[1] = ANGLE_BITS'(unsigned'(i_data.pitch));
    assign w_ang[2] = ANGLE_BITS'(unsigned'(i_data.yaw));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [31:0] ph;
            ph = 32'(w_ang[k]) << (32 - ANGLE_BITS);
            n_head[k].flip = ph[31] ^ ph[30];
            if (n_head[k].flip) ph = ph - 32'h8000_0000;
            n_head[k].z = e2r_pkg::ZW'(signed'(ph));
            n_head[k].x = e2r_pkg::WW'(652032874);
            n_head[k].y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_head <= n_head;
    end

    // Chain of CORDIC cells.
    e2r_pkg::t_lane w_chain [NST+1][3];
    assign w_chain[0] = r_head;

    for (genvar s = 0; s < NST; s++) begin : g_cell
        e2r_cell #(.STAGE(s)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_lane(w_chain[s]),
            .o_lane(w_chain[s+1])
        );
    end

    e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_lane(w_chain[NST]),
        .o_out (o_data)
    );

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    // Input is stalled only when a held result blocks the output.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // An accepted transfer enters the valid pipeline.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

endmodule

FILE: tb/e2r_matrix_checker.sv
// Checker for the Euler angle to rotation matrix block: watches both channels and compares.
module e2r_matrix_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall_in,
    input  e2r_pkg::t_in  i_angles,
    input  logic          i_mat_valid,
    input  logic          i_stall_out,
    input  e2r_pkg::t_out i_matrix,
    output int            o_errors,
    output int            o_pending
);

    localparam int ABITS  = e2r_pkg::ANGLE_BITS_DEF;
    localparam int OFRAC  = e2r_pkg::FRAC_BITS_DEF;
    localparam int NSTAGE = e2r_pkg::CORDIC_STAGES_DEF;
    localparam int WFRAC  = e2r_pkg::WORK_FRAC;
    localparam longint ONE_Q30 = 64'sd1 << WFRAC;

    // Per-step arctangent, 2^32 units per turn.
    longint atan_lut [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    e2r_pkg::t_out matrix_queue[$];

    function automatic longint clamp_q(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Rotation-mode CORDIC over one binary angle, with quadrant fold.
    function automatic void angle_sincos(logic [15:0] ang, output longint s,
                                         output longint c);
        logic [31:0] phase;
        logic        flip;
        longint      x, y, z, dx, dy;
        phase = 32'(ang[ABITS-1:0]) << (32 - ABITS);
        flip  = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
        if (flip) phase = phase - 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'($signed(phase));
        for (int i = 0; i < NSTAGE && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_lut[i];
            end else begin
                x += dx; y -= dy; z += atan_lut[i];
            end
        end
        x = clamp_q(x, ONE_Q30);
        y = clamp_q(y, ONE_Q30);
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 << (WFRAC - 1))) >>> WFRAC;
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        int sh;
        sh = WFRAC - OFRAC;
        v = (v + (64'sd1 << (sh - 1))) >>> sh;
        return 16'(clamp_q(v, 64'sd1 << OFRAC));
    endfunction

    function automatic e2r_pkg::t_out dcm_of(e2r_pkg::t_in a);
        longint sr, cr, sp, cp, sy, cy, srsp, crsp;
        e2r_pkg::t_out m;
        angle_sincos(a.roll, sr, cr);
        angle_sincos(a.pitch, sp, cp);
        angle_sincos(a.yaw, sy, cy);
        srsp  = qmul(sr, sp);
        crsp  = qmul(cr, sp);
        m.m11 = to_q14(qmul(cp, cy));
        m.m12 = to_q14(qmul(cp, sy));
        m.m13 = to_q14(-sp);
        m.m21 = to_q14(qmul(srsp, cy) - qmul(cr, sy));
        m.m22 = to_q14(qmul(srsp, sy) + qmul(cr, cy));
        m.m23 = to_q14(qmul(sr, cp));
        m.m31 = to_q14(qmul(crsp, cy) + qmul(sr, sy));
        m.m32 = to_q14(qmul(crsp, sy) - qmul(sr, cy));
        m.m33 = to_q14(qmul(cr, cp));
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        e2r_pkg::t_out want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) matrix_queue.push_back(dcm_of(i_angles));
            if (i_mat_valid && !i_stall_out) begin
                if (matrix_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = matrix_queue.pop_front();
                    if (i_matrix.m11 !== want.m11) report_mismatch("m11", i_matrix.m11, want.m11);
                    if (i_matrix.m12 !== want.m12) report_mismatch("m12", i_matrix.m12, want.m12);
                    if (i_matrix.m13 !== want.m13) report_mismatch("m13", i_matrix.m13, want.m13);
                    if (i_matrix.m21 !== want.m21) report_mismatch("m21", i_matrix.m21, want.m21);
                    if (i_matrix.m22 !== want.m22) report_mismatch("m22", i_matrix.m22, want.m22);
                    if (i_matrix.m23 !== want.m23) report_mismatch("m23", i_matrix.m23, want.m23);
                    if (i_matrix.m31 !== want.m31) report_mismatch("m31", i_matrix.m31, want.m31);
                    if (i_matrix.m32 !== want.m32) report_mismatch("m32", i_matrix.m32, want.m32);
                    if (i_matrix.m33 !== want.m33) report_mismatch("m33", i_matrix.m33, want.m33);
                end
            end
        end
        o_pending = matrix_queue.size();
    end
endmodule

FILE: tb/tb_euler_to_rotation_matrix.sv
// Testbench top for the Euler angle to rotation matrix block: stimulus and verdict.
module tb_euler_to_rotation_matrix;

    localparam int LATENCY = e2r_pkg::CORDIC_STAGES_DEF + 5;
    localparam int N_RANDOM = 1500;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    e2r_pkg::t_in  i_data = '0;
    logic          o_stall;
    logic          o_valid;
    e2r_pkg::t_out o_data;
    int            fail_count;
    int            pending;
    bit            calm_sink = 1'b0;
    bit            hold_sink = 1'b0;

    always #5 i_clk = ~i_clk;

    euler_to_rotation_matrix uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data
    );

    e2r_matrix_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_angles(i_data),
        .i_mat_valid(o_valid), .i_stall_out(i_stall), .i_matrix(o_data),
        .o_errors(fail_count), .o_pending(pending)
    );

    // Interesting angles: zero, quarter turns, octants, fold edges and extremes.
    function automatic logic [15:0] edge_angle(int k);
        logic [15:0] marks [12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                                    16'h7FFF, 16'h8001, 16'h3FFF, 16'h4001, 16'hBFFF,
                                    16'hFFFF, 16'h0001};
        return marks[k % 12];
    endfunction

    // Send one triple and hold it until the block takes it.
    task automatic send_angles(e2r_pkg::t_in a, bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < 31) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_data  <= a;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver stall: random, with a calm stretch and a long hold-off.
    always @(negedge i_clk) begin
        if (hold_sink) i_stall <= 1'b1;
        else if (calm_sink) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 31);
    end

    initial begin
        e2r_pkg::t_in a;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: edge angles on every field, including minus pi.
        for (int k = 0; k < 24; k++) begin
            a.roll  = edge_angle(k);
            a.pitch = edge_angle(k + 5);
            a.yaw   = edge_angle(k * 7 + 2);
            send_angles(a, 1'b0);
        end

        // Long hold-off on the receiver while items keep coming.
        fork
            begin
                hold_sink = 1'b1;
                repeat (LATENCY * 3) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < LATENCY * 2; k++) begin
                a = e2r_pkg::t_in'(48'({$urandom, $urandom}));
                send_angles(a, 1'b0);
            end
        join

        // Random items; a stretch in the middle runs with no idling on either side.
        for (int k = 0; k < N_RANDOM; k++) begin
            calm_sink = (k >= 600 && k < 800);
            a.roll  = ($urandom_range(7) == 0) ? edge_angle($urandom_range(11)) : 16'($urandom);
            a.pitch = ($urandom_range(7) == 0) ? edge_angle($urandom_range(11)) : 16'($urandom);
            a.yaw   = ($urandom_range(7) == 0) ? edge_angle($urandom_range(11)) : 16'($urandom);
            send_angles(a, !calm_sink);
        end
        i_valid <= 1'b0;
        calm_sink = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS euler_to_rotation_matrix");
        end else begin
            $display("FAIL euler_to_rotation_matrix");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #400000;
        $display("FAIL euler_to_rotation_matrix");
        $finish;
    end
endmodule
